/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_CLKD(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* rtl/core/sfrc_pkg.sv */
`timescale 1ns / 1ps

package sfrc_pkg;

  localparam int unsigned MaxFrameBytes = 64;
  localparam int unsigned AddrW         = $clog2(MaxFrameBytes);
  localparam int unsigned CntW          = $clog2(MaxFrameBytes + 1);

  localparam logic [7:0]  SymStart = 8'd253;
  localparam logic [7:0]  SymEnd   = 8'd254;
  localparam logic [7:0]  SymEsc   = 8'd255;

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'h1021;

  localparam int unsigned MinFrame = 4;
  localparam int unsigned IdBytes  = 2;
  localparam int unsigned CrcBytes = 2;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned IdW      = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 6;
  localparam int unsigned OutDataW = 32;

  // One byte of CRC16-CCITT, most significant bit first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      if (c[15] ^ b[i]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/stuffed_frame_receiver_crc16.sv */
// Receive: one byte per cycle while no frame check or readout runs (tready high).
// Frame end: a check pass reads the n stored bytes at one per cycle; the verdict is taken in
// the cycle after the last read. Each payload result is then read from the buffer and loaded
// into the output register (read then load); an empty payload loads its single result unread.
// Reset (rst_ni low, asynchronous): hunting, no escape, empty buffer, no result pending.
// The frame buffer itself is not cleared; only entries written in the current frame are read.
`timescale 1ns / 1ps

module stuffed_frame_receiver_crc16 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] rx_byte
  input  logic [sfrc_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [15:0] frame_id, [23:16] payload_byte, [29:24] payload_len,
  // [30] has_payload, [31] zero fill
  output logic [sfrc_pkg::OutDataW-1:0] m_axis_tdata_o,
  // last
  output logic                          m_axis_tlast_o
);
  import sfrc_pkg::*;

  // The controller walks through receive, check and readout. The frame buffer
  // is a single-port-read memory with a registered read. Writes only
  // happen while receiving and reads only while checking or reading out, so an
  // entry is never read and written in overlapping cycles.
  typedef enum logic [2:0] {
    ST_RX,
    ST_CHK,
    ST_FIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMPTY
  } state_e;

  state_e            state_q;
  logic              in_frame_q;
  logic              esc_q;
  logic [CntW-1:0]   count_q;

  // Check pass: read index, and the index of the byte now in the read register.
  logic [CntW-1:0]   rd_idx_q;
  logic              pv_q;
  logic [AddrW-1:0]  pidx_q;

  logic [15:0]       crc_q;
  logic [IdW-1:0]    id_q;
  logic [7:0]        rx_hi_q;
  logic [AddrW-1:0]  em_idx_q;

  logic              ovalid_q;
  logic [OutDataW-1:0] odata_q;
  logic              olast_q;

  logic [ByteW-1:0]  mem [MaxFrameBytes];
  logic [ByteW-1:0]  rd_data_q;

  logic              accept;
  logic [7:0]        b;
  logic              is_special;
  logic              full;
  logic              drop;
  logic              mem_we;
  logic              mem_re;
  logic [AddrW-1:0]  rd_addr;
  logic              crc_ok;
  logic [LenW-1:0]   len;
  logic              em_last;
  logic              out_free;
  logic              chk_last;
  logic [CntW-1:0]   crc_end;

  assign b          = s_axis_tdata_i;
  assign accept     = s_axis_tvalid_i && (state_q == ST_RX);
  assign is_special = (b == SymStart) || (b == SymEnd) || (b == SymEsc);
  assign full       = (count_q == CntW'(MaxFrameBytes));
  // While the buffer is full, anything but a start byte is ignored outright.
  assign drop       = (b != SymStart) && full;

  // A byte is stored when it is an escaped special byte or a plain data byte.
  assign mem_we = accept && !drop &&
                  ((esc_q && is_special && !full) ||
                   (!esc_q && in_frame_q && !is_special));

  assign mem_re  = (state_q == ST_CHK) || (state_q == ST_EMIT_RD);
  assign rd_addr = (state_q == ST_CHK) ? rd_idx_q[AddrW-1:0] : em_idx_q;

  assign chk_last = (rd_idx_q == count_q - CntW'(1));
  assign crc_end  = count_q - CntW'(CrcBytes);

  // The low CRC byte is the last one read; it sits in the read register
  // during the verdict cycle.
  assign crc_ok   = (crc_q == {rx_hi_q, rd_data_q});
  assign len      = LenW'(count_q - CntW'(MinFrame));
  assign em_last  = ({1'b0, em_idx_q} == count_q - CntW'(CrcBytes + 1));
  assign out_free = !ovalid_q || m_axis_tready_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AddrW-1:0]] <= b;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RX;
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      count_q    <= '0;
      rd_idx_q   <= '0;
      pv_q       <= 1'b0;
      pidx_q     <= '0;
      crc_q      <= CrcInit;
      id_q       <= '0;
      rx_hi_q    <= '0;
      em_idx_q   <= '0;
      ovalid_q   <= 1'b0;
      odata_q    <= '0;
      olast_q    <= 1'b0;
    end else begin
      pv_q   <= (state_q == ST_CHK);
      pidx_q <= rd_idx_q[AddrW-1:0];

      if (ovalid_q && m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end

      // Consume the byte that the check pass read in the previous cycle.
      if (pv_q) begin
        if ({1'b0, pidx_q} < crc_end) begin
          crc_q <= crc16_byte(crc_q, rd_data_q);
        end
        if (pidx_q == AddrW'(0)) begin
          id_q[15:8] <= rd_data_q;
        end
        if (pidx_q == AddrW'(1)) begin
          id_q[7:0] <= rd_data_q;
        end
        if ({1'b0, pidx_q} == crc_end) begin
          rx_hi_q <= rd_data_q;
        end
      end

      unique case (state_q)
        ST_RX: begin
          if (accept && !drop) begin
            if (esc_q) begin
              esc_q <= 1'b0;
              if (mem_we) begin
                count_q <= count_q + CntW'(1);
              end
            end else if (in_frame_q) begin
              if (b == SymStart) begin
                count_q <= '0;
              end else if (b == SymEnd) begin
                in_frame_q <= 1'b0;
                if (count_q < CntW'(MinFrame)) begin
                  count_q <= '0;
                end else begin
                  rd_idx_q <= '0;
                  crc_q    <= CrcInit;
                  state_q  <= ST_CHK;
                end
              end else if (b == SymEsc) begin
                esc_q <= 1'b1;
              end else begin
                count_q <= count_q + CntW'(1);
              end
            end else if (b == SymStart) begin
              in_frame_q <= 1'b1;
              count_q    <= '0;
            end
          end
        end
        ST_CHK: begin
          rd_idx_q <= rd_idx_q + CntW'(1);
          if (chk_last) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!crc_ok) begin
            count_q <= '0;
            state_q <= ST_RX;
          end else if (len == '0) begin
            state_q <= ST_EMPTY;
          end else begin
            em_idx_q <= AddrW'(IdBytes);
            state_q  <= ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: begin
          state_q <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            odata_q  <= {1'b0, 1'b1, len, rd_data_q, id_q};
            olast_q  <= em_last;
            if (em_last) begin
              count_q <= '0;
              state_q <= ST_RX;
            end else begin
              em_idx_q <= em_idx_q + AddrW'(1);
              state_q  <= ST_EMIT_RD;
            end
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            odata_q  <= {1'b0, 1'b0, {LenW{1'b0}}, {ByteW{1'b0}}, id_q};
            olast_q  <= 1'b1;
            count_q  <= '0;
            state_q  <= ST_RX;
          end
        end
        default: begin
          state_q <= ST_RX;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_RX);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tlast_o  = olast_q;

endmodule

/* rtl/core/sfrc_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfrc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [sfrc_pkg::InDataW-1:0]  s_axis_tdata_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [sfrc_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                          m_axis_tlast_o
);
  import sfrc_pkg::*;

  logic       has_payload;
  logic [5:0] plen;
  logic [7:0] pbyte;

  assign has_payload = m_axis_tdata_o[30];
  assign plen        = m_axis_tdata_o[29:24];
  assign pbyte       = m_axis_tdata_o[23:16];

  // No result is offered in the cycle after reset is seen.
  `ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |=> !m_axis_tvalid_o)

  // A stalled result transaction keeps its contents.
  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))

  // An empty-payload frame gives a single, closing, all-zero payload result.
  `ASSERT_CLKD(a_empty_frame, clk_i, rst_ni, m_axis_tvalid_o && !has_payload |-> m_axis_tlast_o && pbyte == 8'd0 && plen == 6'd0)

  // Payload length never exceeds the buffer less id and CRC, and fill bit is zero.
  `ASSERT_CLKD(a_len_range, clk_i, rst_ni, m_axis_tvalid_o |-> plen <= 6'(MaxFrameBytes - MinFrame) && !m_axis_tdata_o[31])

endmodule

bind stuffed_frame_receiver_crc16 sfrc_checker u_sfrc_checker (.*);

/* dv/tb_stuffed_frame_receiver_crc16.sv */
`timescale 1ns / 1ps

module tb_stuffed_frame_receiver_crc16;
  import sfrc_pkg::*;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  pbyte;
    logic [5:0]  len;
    logic        has;
    logic        last;
  } frame_result_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic [7:0]  s_tdata   = 8'h00;
  logic        s_tready;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;

  stuffed_frame_receiver_crc16 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0]    line_bytes_q[$];   // link bytes waiting to be driven
  frame_result_t frame_results_q[$]; // results the receiver still owes
  logic [7:0]    body_q[$];
  int            bytes_queued = 0;
  int            errors = 0;
  bit            quiet = 1'b0;
  bit            tx_taken = 1'b0;
  int            tx_gap = 0;
  int            rdy_gap = 0;

  // Receiver state as the predictor sees it.
  bit         framing = 1'b0;
  bit         esc_armed = 1'b0;
  int         fill = 0;
  logic [7:0] frame_mem [MaxFrameBytes];

  function automatic logic [15:0] crc_ccitt_upd(logic [15:0] acc, logic [7:0] d);
    acc ^= {d, 8'h00};
    repeat (8) acc = acc[15] ? ((acc << 1) ^ CrcPoly) : (acc << 1);
    return acc;
  endfunction

  function automatic bit is_marker(logic [7:0] b);
    return b == SymStart || b == SymEnd || b == SymEsc;
  endfunction

  task automatic keep_byte(input logic [7:0] b);
    if (fill < MaxFrameBytes) begin
      frame_mem[fill] = b;
      fill++;
    end
  endtask

  task automatic finish_frame();
    int            n;
    int            plen;
    logic [15:0]   crc;
    frame_result_t r;
    n         = fill;
    framing   = 1'b0;
    esc_armed = 1'b0;
    fill      = 0;
    if (n >= MinFrame && n <= MaxFrameBytes) begin
      crc = CrcInit;
      for (int k = 0; k < n - 2; k++) crc = crc_ccitt_upd(crc, frame_mem[k]);
      if (crc == {frame_mem[n-2], frame_mem[n-1]}) begin
        plen   = n - MinFrame;
        r.id   = {frame_mem[0], frame_mem[1]};
        r.len  = plen[5:0];
        if (plen == 0) begin
          r.pbyte = 8'h00;
          r.has   = 1'b0;
          r.last  = 1'b1;
          frame_results_q.push_back(r);
        end else begin
          for (int k = 0; k < plen; k++) begin
            r.pbyte = frame_mem[k+2];
            r.has   = 1'b1;
            r.last  = (k == plen - 1);
            frame_results_q.push_back(r);
          end
        end
      end
    end
  endtask

  // Advances the predicted receiver by one link byte.
  task automatic take_line_byte(input logic [7:0] b);
    if (b != SymStart && fill >= MaxFrameBytes) begin
      // Buffer full: everything but start is dropped.
    end else if (esc_armed) begin
      if (is_marker(b)) keep_byte(b);
      esc_armed = 1'b0;
    end else if (framing) begin
      if (b == SymStart) fill = 0;
      else if (b == SymEnd) finish_frame();
      else if (b == SymEsc) esc_armed = 1'b1;
      else keep_byte(b);
    end else if (b == SymStart) begin
      framing = 1'b1;
      fill    = 0;
    end
  endtask

  // Sender: one nonblocking update of the valid per falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !tx_taken) begin
      s_tvalid <= 1'b1;
    end else if (tx_gap > 0) begin
      tx_gap--;
      s_tvalid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      tx_gap = $urandom_range(1, 13) - 1;
      s_tvalid <= 1'b0;
    end else if (line_bytes_q.size() > 0) begin
      s_tvalid <= 1'b1;
      s_tdata  <= line_bytes_q.pop_front();
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else if (rdy_gap > 0) begin
      rdy_gap--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      rdy_gap = $urandom_range(1, 13) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    frame_result_t w;
    if (rst_ni) begin
      tx_taken = s_tvalid && s_tready;
      if (tx_taken) take_line_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        if (frame_results_q.size() == 0) begin
          $error("unexpected result: frame_id %h payload_byte %h", m_tdata[15:0], m_tdata[23:16]);
          errors++;
        end else begin
          w = frame_results_q.pop_front();
          if (m_tdata[15:0] !== w.id) begin
            $error("frame_id: expected %h, actual %h", w.id, m_tdata[15:0]);
            errors++;
          end
          if (m_tdata[23:16] !== w.pbyte) begin
            $error("payload_byte: expected %h, actual %h", w.pbyte, m_tdata[23:16]);
            errors++;
          end
          if (m_tdata[29:24] !== w.len) begin
            $error("payload_len: expected %0d, actual %0d", w.len, m_tdata[29:24]);
            errors++;
          end
          if (m_tdata[30] !== w.has) begin
            $error("has_payload: expected %b, actual %b", w.has, m_tdata[30]);
            errors++;
          end
          if (m_tlast !== w.last) begin
            $error("last: expected %b, actual %b", w.last, m_tlast);
            errors++;
          end
        end
      end
    end
  end

  task automatic send(input logic [7:0] b);
    line_bytes_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic send_escaped(input logic [7:0] b);
    if (is_marker(b)) send(SymEsc);
    send(b);
  endtask

  task automatic fill_body(input int n);
    body_q.delete();
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) body_q.push_back(8'(SymStart + $urandom_range(0, 2)));
      else body_q.push_back(8'($urandom));
    end
  endtask

  // Frames id + body_q + CRC; junk adds dropped escape pairs, bad corrupts the CRC.
  task automatic send_frame(input logic [15:0] id, input bit bad, input bit junk);
    logic [7:0]  raw[$];
    logic [15:0] crc;
    raw = {id[15:8], id[7:0]};
    foreach (body_q[k]) raw.push_back(body_q[k]);
    crc = CrcInit;
    foreach (raw[k]) crc = crc_ccitt_upd(crc, raw[k]);
    if (bad) crc ^= 16'(1) << $urandom_range(0, 15);
    raw.push_back(crc[15:8]);
    raw.push_back(crc[7:0]);
    send(SymStart);
    foreach (raw[k]) begin
      if (junk && $urandom_range(0, 7) == 0) begin
        send(SymEsc);
        send(8'($urandom_range(0, 252)));
      end
      send_escaped(raw[k]);
    end
    send(SymEnd);
  endtask

  task automatic send_good_random();
    int n;
    n = ($urandom_range(0, 14) == 0) ? $urandom_range(9, 59) : $urandom_range(0, 8);
    fill_body(n);
    send_frame(16'($urandom), 1'b0, $urandom_range(0, 2) == 0);
  endtask

  // Fills the buffer past its end; the end byte is then dropped and the
  // receiver stays in the frame until the next start.
  task automatic send_overflow();
    send(SymStart);
    repeat ($urandom_range(64, 70)) send(8'($urandom_range(0, 252)));
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 2))
        0: send(SymEnd);
        1: send(SymEsc);
        default: send(8'($urandom_range(0, 252)));
      endcase
    end
  endtask

  initial begin
    int pick;
    int stop_at;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: noise while hunting, then the corner frames.
    send(8'h00); send(SymEsc); send(SymEnd); send(8'h7F);
    fill_body(0);
    send_frame(16'h0000, 1'b0, 1'b0);
    body_q = {SymStart, SymEsc};
    send_frame(16'hFFFF, 1'b0, 1'b0);
    send(SymStart); send(8'h12); send(8'h34); send(SymEnd);
    body_q = {8'h55};
    send_frame(16'h1234, 1'b1, 1'b0);
    send(SymStart); send(8'h99); send(SymEsc); send(8'h41);
    body_q = {SymEnd, 8'h80};
    send_frame(16'hA5A5, 1'b0, 1'b1);

    // Queue nothing more until the receiver has delivered everything.
    while (line_bytes_q.size() != 0 || s_tvalid || frame_results_q.size() != 0)
      @(posedge clk_i);

    // The frame that can never close.
    send_overflow();

    stop_at = 150;
    while (bytes_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        send_good_random();
      end else if (pick < 72) begin
        fill_body($urandom_range(0, 6));
        send_frame(16'($urandom), 1'b1, 1'b0);
      end else if (pick < 80) begin
        send(SymStart);
        repeat ($urandom_range(0, 3)) send(8'($urandom_range(0, 252)));
        send(SymEnd);
      end else if (pick < 88) begin
        send(SymStart);
        repeat ($urandom_range(1, 6)) send_escaped(8'($urandom));
        send_good_random();
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 6)) begin
          pick = $urandom_range(0, 253);
          send(pick == 253 ? SymEnd : 8'(pick));
        end
      end else begin
        send_overflow();
      end
    end

    quiet = 1'b1;
    repeat (2) send_good_random();

    while (line_bytes_q.size() != 0 || s_tvalid || frame_results_q.size() != 0)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);

    if (errors == 0 && frame_results_q.size() == 0) begin
      $display("stuffed_frame_receiver_crc16: match");
    end else begin
      $display("stuffed_frame_receiver_crc16: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("stuffed_frame_receiver_crc16: mismatch");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/sfrc_pkg.sv
rtl/core/stuffed_frame_receiver_crc16.sv
rtl/core/sfrc_checker.sv
dv/tb_stuffed_frame_receiver_crc16.sv
